>>> rtl/qpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpht_pkg
// Shared types and constants of the quadratic-probe hash table.
// ----------------------------------------------------------------------------
package qpht_pkg;

    localparam int DEFAULT_TABLE_SLOTS = 16;

    localparam int KEY_W      = 31;
    localparam int VALUE_W    = 64;
    localparam int SLOT_OUT_W = 4;
    localparam int STATUS_W   = 3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_INSERTED  = 3'd0,
        STATUS_DUPLICATE = 3'd1,
        STATUS_FULL      = 3'd2,
        STATUS_FOUND     = 3'd3,
        STATUS_NOT_FOUND = 3'd4
    } status_t;

    typedef struct packed {
        logic flag_we;
        logic entry_we;
        logic occ;
    } mem_wr_t;

endpackage

>>> rtl/qpht_home.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpht_home
// Home slot unit: key modulo the table size. A mask for a power-of-two size,
// otherwise a reciprocal multiplication with one correction step.
// ----------------------------------------------------------------------------
module qpht_home #(
    parameter int TABLE_SLOTS = qpht_pkg::DEFAULT_TABLE_SLOTS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [qpht_pkg::KEY_W-1:0]     key,
    output logic                           done,
    output logic [$clog2(TABLE_SLOTS)-1:0] home
);
    import qpht_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_SLOTS);

    generate
        if ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0)
        begin : g_pow2
            logic              done_reg;
            logic [SLOT_W-1:0] home_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    home_reg <= key[SLOT_W-1:0];
                end
            end

            assign done = done_reg;
            assign home = home_reg;
        end
        else
        begin : g_recip
            localparam int              SHIFT_C    = KEY_W + SLOT_W;
            localparam int              PROD_W     = 2 * KEY_W + 1;
            localparam logic [63:0]     RECIP_FULL = (64'd1 << SHIFT_C) / 64'(TABLE_SLOTS);
            localparam logic [KEY_W:0]  RECIP_C    = RECIP_FULL[KEY_W:0];
            localparam logic [SLOT_W:0] SLOTS_C    = (SLOT_W + 1)'(TABLE_SLOTS);

            logic              mul_vld_reg;
            logic              sub_vld_reg;
            logic              done_reg;
            logic [PROD_W-1:0] prod_reg;
            logic [SLOT_W:0]   key_lo_reg;
            logic [SLOT_W:0]   rem_reg;
            logic [SLOT_W-1:0] home_reg;
            logic [SLOT_W:0]   quo_lo;
            logic [SLOT_W:0]   quo_mul;
            logic [SLOT_W:0]   rem_fold;

            always_comb
            begin
                quo_lo   = prod_reg[SHIFT_C+SLOT_W:SHIFT_C];
                quo_mul  = quo_lo * SLOTS_C;
                rem_fold = (rem_reg >= SLOTS_C) ? (rem_reg - SLOTS_C) : rem_reg;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    mul_vld_reg <= 1'b0;
                    sub_vld_reg <= 1'b0;
                    done_reg    <= 1'b0;
                end
                else
                begin
                    mul_vld_reg <= start;
                    sub_vld_reg <= mul_vld_reg;
                    done_reg    <= sub_vld_reg;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    prod_reg   <= PROD_W'(key) * PROD_W'(RECIP_C);
                    key_lo_reg <= key[SLOT_W:0];
                end
                if (mul_vld_reg)
                begin
                    rem_reg <= key_lo_reg - quo_mul;
                end
                if (sub_vld_reg)
                begin
                    home_reg <= rem_fold[SLOT_W-1:0];
                end
            end

            assign done = done_reg;
            assign home = home_reg;
        end
    endgenerate

endmodule

>>> rtl/qpht_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpht_mem
// Table storage: occupancy flag memory and key/value entry memory, one write
// port and one registered read port each, sharing the addresses.
// ----------------------------------------------------------------------------
module qpht_mem #(
    parameter int TABLE_SLOTS = qpht_pkg::DEFAULT_TABLE_SLOTS
) (
    input  logic                           clk,
    input  qpht_pkg::mem_wr_t              wr,
    input  logic [$clog2(TABLE_SLOTS)-1:0] wr_addr,
    input  logic [qpht_pkg::KEY_W-1:0]     wr_key,
    input  logic [qpht_pkg::VALUE_W-1:0]   wr_value,
    input  logic [$clog2(TABLE_SLOTS)-1:0] rd_addr,
    output logic                           rd_occ,
    output logic [qpht_pkg::KEY_W-1:0]     rd_key,
    output logic [qpht_pkg::VALUE_W-1:0]   rd_value
);
    import qpht_pkg::*;

    logic                     flag_mem  [TABLE_SLOTS];
    logic [KEY_W+VALUE_W-1:0] entry_mem [TABLE_SLOTS];
    logic                     occ_reg;
    logic [KEY_W+VALUE_W-1:0] entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr.flag_we)
        begin
            flag_mem[wr_addr] <= wr.occ;
        end
        occ_reg <= flag_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr.entry_we)
        begin
            entry_mem[wr_addr] <= {wr_key, wr_value};
        end
        entry_reg <= entry_mem[rd_addr];
    end

    assign rd_occ   = occ_reg;
    assign rd_key   = entry_reg[KEY_W+VALUE_W-1:VALUE_W];
    assign rd_value = entry_reg[VALUE_W-1:0];

endmodule

>>> rtl/quadratic_probe_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// Open-addressing key/value table with quadratic probing, one result per
// request.
// ----------------------------------------------------------------------------
// One request at a time. Each request makes P probes, where P is 1 to
// TABLE_SLOTS: the table memory delivers one slot per cycle, and the next
// probe address is read while the current slot is checked. When TABLE_SLOTS
// is not a power of two the home slot comes from a reciprocal multiplication.
// After reset the occupancy memory is cleared one slot at a time, during
// which in_stall stays high.
module quadratic_probe_hash_table #(
    parameter int TABLE_SLOTS = qpht_pkg::DEFAULT_TABLE_SLOTS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              operation,
    input  logic [qpht_pkg::KEY_W-1:0]        key,
    input  logic [qpht_pkg::VALUE_W-1:0]      value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [qpht_pkg::STATUS_W-1:0]     status,
    output logic [qpht_pkg::SLOT_OUT_W-1:0]   slot,
    output logic [qpht_pkg::VALUE_W-1:0]      found_value
);
    import qpht_pkg::*;

    localparam int               SLOT_W  = $clog2(TABLE_SLOTS);
    localparam logic [SLOT_W:0]  SLOTS_C = (SLOT_W + 1)'(TABLE_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_C = SLOT_W'(TABLE_SLOTS - 1);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_HOME  = 5'b00100,
        ST_LOOK  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   clr_reg, clr_next;
    logic [SLOT_W-1:0]   cur_slot_reg, cur_slot_next;
    logic [SLOT_W-1:0]   inc_reg, inc_next;
    logic [SLOT_W-1:0]   probe_reg, probe_next;
    logic                op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [VALUE_W-1:0]  value_reg;
    status_t             res_status_reg, res_status_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic [VALUE_W-1:0]  res_value_reg, res_value_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [VALUE_W-1:0]  out_value_reg;

    logic                in_accept;
    logic                out_free;
    logic                out_load;
    logic                home_done;
    logic [SLOT_W-1:0]   home_slot;
    logic [SLOT_W:0]     slot_sum;
    logic [SLOT_W-1:0]   next_slot;
    logic [SLOT_W:0]     inc_sum;
    logic [SLOT_W-1:0]   inc_step;
    mem_wr_t             wr;
    logic [SLOT_W-1:0]   wr_addr;
    logic [SLOT_W-1:0]   rd_addr;
    logic                rd_occ;
    logic [KEY_W-1:0]    rd_key;
    logic [VALUE_W-1:0]  rd_value;
    logic                hit_free;
    logic                hit_key;

    qpht_home #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_home (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_accept),
        .key   (key),
        .done  (home_done),
        .home  (home_slot)
    );

    qpht_mem #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_mem (
        .clk      (clk),
        .wr       (wr),
        .wr_addr  (wr_addr),
        .wr_key   (key_reg),
        .wr_value (value_reg),
        .rd_addr  (rd_addr),
        .rd_occ   (rd_occ),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == ST_DONE) && out_free;
    assign hit_free  = !rd_occ;
    assign hit_key   = (rd_key == key_reg);

    always_comb
    begin
        slot_sum  = {1'b0, cur_slot_reg} + {1'b0, inc_reg};
        next_slot = (slot_sum >= SLOTS_C) ? SLOT_W'(slot_sum - SLOTS_C)
                                          : slot_sum[SLOT_W-1:0];
        inc_sum   = {1'b0, inc_reg} + (SLOT_W + 1)'(2);
        inc_step  = (inc_sum >= SLOTS_C) ? SLOT_W'(inc_sum - SLOTS_C)
                                         : inc_sum[SLOT_W-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        cur_slot_next   = cur_slot_reg;
        inc_next        = inc_reg;
        probe_next      = probe_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg && out_stall;
        wr              = '0;
        wr_addr         = cur_slot_reg;
        rd_addr         = next_slot;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr.flag_we = 1'b1;
                wr_addr    = clr_reg;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == LAST_C)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_HOME;
                end
            end
            ST_HOME:
            begin
                rd_addr = home_slot;
                if (home_done)
                begin
                    cur_slot_next = home_slot;
                    inc_next      = SLOT_W'(1);
                    probe_next    = '0;
                    state_next    = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                res_slot_next  = '0;
                res_value_next = '0;
                priority if (hit_free)
                begin
                    state_next = ST_DONE;
                    if (op_reg == OP_INSERT)
                    begin
                        wr.flag_we      = 1'b1;
                        wr.entry_we     = 1'b1;
                        wr.occ          = 1'b1;
                        res_status_next = STATUS_INSERTED;
                        res_slot_next   = cur_slot_reg;
                    end
                    else
                    begin
                        res_status_next = STATUS_NOT_FOUND;
                    end
                end
                else if (hit_key)
                begin
                    state_next    = ST_DONE;
                    res_slot_next = cur_slot_reg;
                    if (op_reg == OP_INSERT)
                    begin
                        res_status_next = STATUS_DUPLICATE;
                    end
                    else
                    begin
                        res_status_next = STATUS_FOUND;
                        res_value_next  = rd_value;
                    end
                end
                else if (probe_reg == LAST_C)
                begin
                    state_next      = ST_DONE;
                    res_status_next = (op_reg == OP_INSERT) ? STATUS_FULL
                                                            : STATUS_NOT_FOUND;
                end
                else
                begin
                    cur_slot_next = next_slot;
                    inc_next      = inc_step;
                    probe_next    = probe_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg    <= operation;
            key_reg   <= key;
            value_reg <= value;
        end
        cur_slot_reg   <= cur_slot_next;
        inc_reg        <= inc_next;
        probe_reg      <= probe_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_value_reg  <= res_value_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_value_reg  <= res_value_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign slot        = SLOT_OUT_W'(out_slot_reg);
    assign found_value = out_value_reg;

`ifndef ASSERT_OFF
    a_insert_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        wr.entry_we |-> (state_reg == ST_LOOK) && !rd_occ && (op_reg == OP_INSERT))
        else $error("entry write to an occupied slot");

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOK) |-> ({1'b0, cur_slot_reg} < SLOTS_C))
        else $error("probe slot beyond table size");

    a_no_slot_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (res_status_reg == STATUS_FULL ||
                      res_status_reg == STATUS_NOT_FOUND))
        |=> (out_slot_reg == '0))
        else $error("slot reported for a miss");

    a_value_only_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != STATUS_FOUND) |-> (out_value_reg == '0))
        else $error("value reported without a match");
`endif

endmodule
